>>> hw/rtl/tgpc_pkg.sv
// Shared constants and types for the three-Gaussian field evaluator.
`default_nettype none
package tgpc_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_CONSTANT = 8'd0;
    localparam logic [7:0] REG_SHAPE_0  = 8'd1;
    localparam logic [7:0] REG_SHAPE_1  = 8'd2;
    localparam logic [7:0] REG_SHAPE_2  = 8'd3;
    localparam logic [7:0] REG_CENTER_0 = 8'd4;
    localparam logic [7:0] REG_CENTER_1 = 8'd5;
    localparam logic [7:0] REG_CENTER_2 = 8'd6;
    localparam logic [7:0] REG_TSCALE   = 8'd7;

    localparam int NUM_GAUSS = 3;
    localparam int TERM_W    = 26;

    // log2(e) in Q.16 and ln2 in Q.32
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    localparam logic [23:0] TSCALE_RESET = 24'd65536;
    localparam logic [31:0] A_MAX        = 32'hFFFF_FFFF;
    localparam logic [31:0] SUM_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] SUM_MIN      = 32'h8000_0000;

    typedef logic signed [TERM_W-1:0] term_t;

endpackage
`default_nettype wire

>>> hw/rtl/tgpc_lane.sv
// One Gaussian lane: distance, exponent, exp table lookup and amplitude weighting.
`default_nettype none
module tgpc_lane #(
    parameter int DIMENSIONS      = 3,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic                      clk,
    input  wire logic [8:0]                en,
    input  wire logic [47:0]               coords,
    input  wire logic [47:0]               center,
    input  wire logic [47:0]               shape,
    input  wire logic [23:0]               time_scale,
    output tgpc_pkg::term_t                term
);
    localparam int IDX_W   = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int FPROD_W = 16 + DEPTH_W;

    typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

    // 2^(-i/DEPTH) in Q1.16 from the series of exp(-u) up to the u^13 term
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] u;
        logic [63:0] tm;
        logic [63:0] pos;
        logic [63:0] neg;
        int          i;
        int          n;
        for (i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            u   = (64'(i) * tgpc_pkg::LN2_Q32) / EXP_TABLE_DEPTH;
            tm  = 64'd1 << 32;
            pos = tm;
            neg = 64'd0;
            for (n = 1; n <= 13; n++)
            begin
                tm = ((tm * u) >> 32) / 64'(n);
                if (n % 2 == 1)
                    neg = neg + tm;
                else
                    pos = pos + tm;
            end
            r[i] = 17'(((pos - neg) + 64'h8000) >> 16);
        end
        return r;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    logic signed [16:0] d_next [3];
    logic signed [16:0] d_reg  [3];
    logic [31:0]        p_reg;
    logic [31:0]        sq_reg [3];
    logic [47:0]        k_reg;
    logic [33:0]        r2_reg;
    logic [47:0]        k2_reg;
    logic [40:0]        pp_reg [4];
    logic [81:0]        full;
    logic [31:0]        a_reg;
    logic [48:0]        t_reg;
    logic [FPROD_W-1:0] fprod;
    logic [IDX_W-1:0]   idx_reg;
    logic [4:0]         sh_reg;
    logic               zero_reg;
    logic [16:0]        rom_reg;
    logic [4:0]         sh2_reg;
    logic               zero2_reg;
    logic [16:0]        e_val;
    logic signed [41:0] prod;
    tgpc_pkg::term_t    term_reg;

    // Offsets from the center, unused axes forced to zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (i < DIMENSIONS)
                d_next[i] = 17'($signed(coords[16*i +: 16])) - 17'($signed(center[16*i +: 16]));
            else
                d_next[i] = '0;
        end
    end

    // Stage 1: offsets and scaled inverse width
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg <= d_next;
            p_reg <= 32'((48'(shape[23:0]) * 48'(time_scale)) >> 16);
        end
    end

    // Stage 2: squares
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 32'(d_reg[i] * d_reg[i]);
            k_reg <= 48'((64'(p_reg) * 64'(p_reg)) >> 16);
        end
    end

    // Stage 3: squared distance
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            r2_reg <= 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);
            k2_reg <= k_reg;
        end
    end

    // Stage 4: partial products of r2 * k
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pp_reg[0] <= 41'(r2_reg[16:0])  * 41'(k2_reg[23:0]);
            pp_reg[1] <= 41'(r2_reg[16:0])  * 41'(k2_reg[47:24]);
            pp_reg[2] <= 41'(r2_reg[33:17]) * 41'(k2_reg[23:0]);
            pp_reg[3] <= 41'(r2_reg[33:17]) * 41'(k2_reg[47:24]);
        end
    end

    // Stage 5: exponent, clamped
    assign full = 82'(pp_reg[0]) + (82'(pp_reg[1]) << 24) + (82'(pp_reg[2]) << 17)
                + (82'(pp_reg[3]) << 41);

    always_ff @(posedge clk)
    begin
        if (en[4])
            a_reg <= (|full[81:48]) ? tgpc_pkg::A_MAX : full[47:16];
    end

    // Stage 6: convert to base 2
    always_ff @(posedge clk)
    begin
        if (en[5])
            t_reg <= 49'(a_reg) * 49'(tgpc_pkg::LOG2E_Q16);
    end

    // Stage 7: table index and shift
    assign fprod = FPROD_W'(t_reg[31:16]) * FPROD_W'(EXP_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            idx_reg  <= fprod[16 +: IDX_W];
            sh_reg   <= t_reg[36:32];
            zero_reg <= |t_reg[48:37];
        end
    end

    // Stage 8: table read
    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            rom_reg   <= EXP_ROM[idx_reg];
            sh2_reg   <= sh_reg;
            zero2_reg <= zero_reg;
        end
    end

    // Stage 9: shift and weight by amplitude, floor divide by 2^16
    assign e_val = zero2_reg ? 17'd0 : (rom_reg >> sh2_reg);
    assign prod  = 42'($signed(shape[47:24])) * 42'($signed({1'b0, e_val}));

    always_ff @(posedge clk)
    begin
        if (en[8])
            term_reg <= tgpc_pkg::TERM_W'(prod >>> 16);
    end

    assign term = term_reg;

endmodule
`default_nettype wire

>>> hw/rtl/triple_gaussian_plus_constant_eval.sv
// Top level: configuration registers, pipeline control and final saturating sum.
// Evaluates constant + sum of three weighted Gaussians for one point per clock
// while the output accepts. Throughput when not stalled is one point per cycle,
// set by three parallel nine-stage lanes feeding one registered sum stage, each
// lane with its own registered exp table ROM of EXP_TABLE_DEPTH entries. Stages
// hold independently, so a stall at the output lets the pipeline fill its bubbles
// before backpressuring the input.
// Configuration must only be written while the pipeline is empty.
`default_nettype none
module triple_gaussian_plus_constant_eval #(
    parameter int DIMENSIONS      = 3,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // damping_value
    output logic             m_axis_tuser,   // saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    localparam int NSTG = 10;

    logic [31:0]     constant_reg;
    logic [47:0]     shape_reg  [tgpc_pkg::NUM_GAUSS];
    logic [47:0]     center_reg [tgpc_pkg::NUM_GAUSS];
    logic [23:0]     tscale_reg;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;
    tgpc_pkg::term_t term [tgpc_pkg::NUM_GAUSS];
    logic signed [33:0] sum;
    logic [31:0]     value_next;
    logic            sat_next;
    logic [31:0]     value_reg;
    logic            sat_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            constant_reg <= '0;
            tscale_reg   <= tgpc_pkg::TSCALE_RESET;
            for (int g = 0; g < tgpc_pkg::NUM_GAUSS; g++)
            begin
                shape_reg[g]  <= '0;
                center_reg[g] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tgpc_pkg::REG_CONSTANT: constant_reg  <= cfg_data[31:0];
                tgpc_pkg::REG_SHAPE_0:  shape_reg[0]  <= cfg_data;
                tgpc_pkg::REG_SHAPE_1:  shape_reg[1]  <= cfg_data;
                tgpc_pkg::REG_SHAPE_2:  shape_reg[2]  <= cfg_data;
                tgpc_pkg::REG_CENTER_0: center_reg[0] <= cfg_data;
                tgpc_pkg::REG_CENTER_1: center_reg[1] <= cfg_data;
                tgpc_pkg::REG_CENTER_2: center_reg[2] <= cfg_data;
                tgpc_pkg::REG_TSCALE:   tscale_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Per-stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_axis_tready;
        for (int j = NSTG - 2; j >= 0; j--)
            en[j] = !v_reg[j] || en[j+1];
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= s_axis_tvalid;
            for (int j = 1; j < NSTG; j++)
                if (en[j])
                    v_reg[j] <= v_reg[j-1];
        end
    end

    // Gaussian lanes
    for (genvar g = 0; g < tgpc_pkg::NUM_GAUSS; g++)
    begin : g_lane
        tgpc_lane #(
            .DIMENSIONS      (DIMENSIONS),
            .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
        ) u_lane (
            .clk        (clk),
            .en         (en[NSTG-2:0]),
            .coords     (s_axis_tdata),
            .center     (center_reg[g]),
            .shape      (shape_reg[g]),
            .time_scale (tscale_reg),
            .term       (term[g])
        );
    end

    // Final sum with saturation
    always_comb
    begin
        sum = 34'($signed(constant_reg)) + 34'(term[0]) + 34'(term[1]) + 34'(term[2]);
        if (sum > 34'sh0_7FFF_FFFF)
        begin
            value_next = tgpc_pkg::SUM_MAX;
            sat_next   = 1'b1;
        end
        else if (sum < -34'sh0_8000_0000)
        begin
            value_next = tgpc_pkg::SUM_MIN;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = sum[31:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_axis_tvalid = v_reg[NSTG-1];
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = sat_reg;

    // A clipped result sits at one of the two rails
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata == tgpc_pkg::SUM_MAX || m_axis_tdata == tgpc_pkg::SUM_MIN))
        else $error("saturated result not at a rail");

    // A held last lane stage never drops its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTG-2] && !en[NSTG-2]) |=> v_reg[NSTG-2])
        else $error("stalled stage lost its transaction");

    // Occupancy grows by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(v_reg) <= $past($countones(v_reg)) + 1))
        else $error("pipeline occupancy jumped");

endmodule
`default_nettype wire
